// ----- rtl/core/lru_cache_lookup_insert_defines.svh -----
// ----------------------------------------------------------------------------
// lru cache assertion macros
// shared concurrent assertion forms for the lru cache block
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_LOOKUP_INSERT_DEFINES_SVH
`define LRU_CACHE_LOOKUP_INSERT_DEFINES_SVH

// same-cycle implication
`define LRUC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lrucache_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru cache package
// transaction types and fixed constants of the lru cache block
// ----------------------------------------------------------------------------
package lrucache_pkg;

  localparam int DATA_BITS = 32;
  localparam int CAP_BITS  = 4;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] key;
    logic [DATA_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] read_value;
    logic                 evicted;
    logic [DATA_BITS-1:0] evicted_key;
  } rsp_t;

endpackage

// ----- rtl/core/lrucache_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru cache entry ram
// one write port, one registered read port
// ----------------------------------------------------------------------------
module lrucache_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lru_cache_lookup_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru cache lookup and insert
// fully associative key/value cache with least recently used replacement
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/ready) carries one transaction: op (get or put), key,
//   value. rsp channel (valid/ready) returns hit, read_value, evicted and
//   evicted_key, one response per request, in order.
//   cap_we/cap_wdata write the capacity register (reset 5); write only idle.
//   a new request is not taken until the current one is through: the scan
//   reads the key and value rams one entry per cycle through a single shared
//   comparator, and is followed by one update step.
//   req_ready is high only while the sequencer is idle.
//   the response sits in an output register; a new request is taken while it
//   waits, but the update step holds until the register is free, so a stalled
//   receiver stalls the block without losing or repeating a response.
//   reset empties the cache and sets capacity to 5; the rams need no clearing.
// ----------------------------------------------------------------------------
`include "lru_cache_lookup_insert_defines.svh"

module lru_cache_lookup_insert #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cap_we,
  input  logic [lrucache_pkg::CAP_BITS-1:0]   cap_wdata,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  lrucache_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output lrucache_pkg::rsp_t                  rsp
);

  import lrucache_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int OCC_W  = CNT_W;
  localparam int RANK_W = IDX_W;
  localparam int CMP_W  = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [ENTRIES-1:0]    valid;
  logic [RANK_W-1:0]     rank [ENTRIES];
  logic [OCC_W-1:0]      occ;
  logic [CAP_BITS-1:0]   capacity;

  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [VALUE_BITS-1:0] hit_val;
  logic                  lru_found;
  logic [IDX_W-1:0]      lru_idx;
  logic [RANK_W-1:0]     lru_rank;
  logic [KEY_BITS-1:0]   lru_key;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      prb;
  logic                  probe;
  logic                  match;

  logic                  out_free;
  logic                  upd;
  logic                  is_put;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      ent_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic [CMP_W-1:0]      occ_ext;
  logic                  empty_zero;
  logic                  ev_self;
  logic                  do_evict;
  logic                  do_insert;
  logic [IDX_W-1:0]      slot;
  logic [ENTRIES-1:0]    valid_next;
  logic [RANK_W-1:0]     rank_next [ENTRIES];
  logic [OCC_W-1:0]      occ_next;
  rsp_t                  rsp_next;

  logic                  kram_we;
  logic                  vram_we;
  logic [IDX_W-1:0]      vram_waddr;

  // scan datapath
  assign req_ready = (state == ST_IDLE);
  assign rd_addr   = cnt[IDX_W-1:0];
  assign prb       = IDX_W'(cnt - CNT_W'(1));
  assign probe     = (state == ST_SCAN) && (cnt != '0);
  assign match     = probe && valid[prb] && (key_rd == key_q);

  // update decisions
  assign out_free   = !rsp_valid || rsp_ready;
  assign upd        = (state == ST_UPDATE) && out_free;
  assign is_put     = (op_q == OP_PUT);
  assign cap_ext    = CMP_W'(capacity);
  assign ent_ext    = CMP_W'(ENTRIES);
  assign cap_eff    = (cap_ext > ent_ext) ? ent_ext : cap_ext;
  assign occ_ext    = CMP_W'(occ);
  assign empty_zero = (occ == '0) && (cap_eff == '0);
  assign ev_self    = is_put && !hit_found && empty_zero;
  assign do_evict   = is_put && !hit_found && !empty_zero && (occ_ext >= cap_eff) && lru_found;

  always_comb begin
    slot      = free_idx;
    do_insert = 1'b0;
    if (is_put && !hit_found && !empty_zero) begin
      if (free_found && (!do_evict || free_idx < lru_idx)) begin
        slot      = free_idx;
        do_insert = 1'b1;
      end else if (do_evict) begin
        slot      = lru_idx;
        do_insert = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_next[i] = valid[i];
      rank_next[i]  = rank[i];
      if (hit_found) begin
        if (IDX_W'(i) == hit_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && rank[i] < hit_rank) begin
          rank_next[i] = RANK_W'(rank[i] + 1'b1);
        end
      end else if (is_put && !empty_zero) begin
        if (do_evict && IDX_W'(i) == lru_idx) begin
          valid_next[i] = 1'b0;
        end
        if (do_insert && IDX_W'(i) == slot) begin
          valid_next[i] = 1'b1;
          rank_next[i]  = '0;
        end else if (valid_next[i]) begin
          rank_next[i] = RANK_W'(rank[i] + 1'b1);
        end
      end
    end
  end

  always_comb begin
    occ_next = occ;
    if (do_evict && !do_insert) begin
      occ_next = OCC_W'(occ - 1'b1);
    end else if (do_insert && !do_evict) begin
      occ_next = OCC_W'(occ + 1'b1);
    end
  end

  always_comb begin
    rsp_next.hit         = hit_found;
    rsp_next.read_value  = (hit_found && !is_put) ? DATA_BITS'(hit_val) : '0;
    rsp_next.evicted     = do_evict || ev_self;
    rsp_next.evicted_key = '0;
    if (ev_self) begin
      rsp_next.evicted_key = DATA_BITS'(key_q);
    end else if (do_evict) begin
      rsp_next.evicted_key = DATA_BITS'(lru_key);
    end
  end

  assign kram_we    = upd && do_insert;
  assign vram_we    = upd && ((hit_found && is_put) || do_insert);
  assign vram_waddr = hit_found ? hit_idx : slot;

  lrucache_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (slot),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lrucache_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (val_q),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cap_we) begin
      capacity <= cap_wdata;
    end
  end

  // sequencer and entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      valid     <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (upd) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op_q       <= req.op;
            key_q      <= KEY_BITS'(req.key);
            val_q      <= VALUE_BITS'(req.value);
            cnt        <= '0;
            hit_found  <= 1'b0;
            lru_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= CNT_W'(cnt + 1'b1);
          if (probe) begin
            if (match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= prb;
              hit_rank  <= rank[prb];
              hit_val   <= val_rd;
            end
            if (valid[prb] && (!lru_found || rank[prb] > lru_rank)) begin
              lru_found <= 1'b1;
              lru_idx   <= prb;
              lru_rank  <= rank[prb];
              lru_key   <= key_rd;
            end
            if (!valid[prb] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= prb;
            end
          end
          if (cnt == CNT_W'(ENTRIES)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            valid     <= valid_next;
            rank      <= rank_next;
            occ       <= occ_next;
            rsp       <= rsp_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LRUC_ASSERT_IMPL(a_occ_bound, clk, rst, 1'b1, occ <= OCC_W'(ENTRIES), "occupancy above entries")
  `LRUC_ASSERT_IMPL(a_occ_count, clk, rst, state == ST_IDLE, $countones(valid) == occ, "occupancy mismatch")
  `LRUC_ASSERT_NEXT(a_rsp_load, clk, rst, upd, rsp_valid, "update without response")
  `LRUC_ASSERT_IMPL(a_hit_no_evict, clk, rst, rsp_valid, !(rsp.hit && rsp.evicted), "hit with eviction")

endmodule

// ----- verif/lru_cache_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru cache checker
// watches the request, response and capacity ports of the lru cache, keeps
// its own copy of the cache contents and recency order, predicts the response
// of every accepted request and compares the responses in order, field by field
// ----------------------------------------------------------------------------
module lru_cache_checker #(
  parameter int ENTRIES     = 8,
  parameter int MAX_REPORTS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cap_we,
  input  logic [lrucache_pkg::CAP_BITS-1:0] cap_wdata,
  input  logic                              req_valid,
  input  logic                              req_ready,
  input  lrucache_pkg::req_t                req,
  input  logic                              rsp_valid,
  input  logic                              rsp_ready,
  input  lrucache_pkg::rsp_t                rsp,
  output int                                outstanding,
  output int                                errors
);

  import lrucache_pkg::*;

  logic [DATA_BITS-1:0] line_key   [ENTRIES];
  logic [DATA_BITS-1:0] line_value [ENTRIES];
  logic                 line_valid [ENTRIES];
  int                   line_age   [ENTRIES];
  int                   fill;
  logic [CAP_BITS-1:0]  capacity;
  rsp_t                 pending_responses [$];

  initial begin
    outstanding = 0;
    errors      = 0;
  end

  function automatic rsp_t lru_access(input req_t r);
    rsp_t res;
    int   slot;
    int   victim;
    int   free_slot;
    int   age;
    int   limit;
    res   = '0;
    limit = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    slot  = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && line_valid[i] && line_key[i] == r.key) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      if (r.op == OP_PUT) line_value[slot] = r.value;
      else res.read_value = line_value[slot];
      // promote to most recent
      age = line_age[slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && i != slot && line_age[i] < age) line_age[i]++;
      end
      line_age[slot] = 0;
    end else if (r.op == OP_PUT) begin
      if (fill == 0 && limit == 0) begin
        res.evicted     = 1'b1;
        res.evicted_key = r.key;
      end else begin
        if (fill >= limit) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
          end
          if (victim >= 0) begin
            res.evicted        = 1'b1;
            res.evicted_key    = line_key[victim];
            line_valid[victim] = 1'b0;
            if (fill > 0) fill--;
          end
        end
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i]) line_age[i]++;
          else if (free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          line_key[free_slot]   = r.key;
          line_value[free_slot] = r.value;
          line_valid[free_slot] = 1'b1;
          line_age[free_slot]   = 0;
          fill++;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_age[i]   = 0;
      end
      fill     = 0;
      capacity = CAP_RESET;
      pending_responses.delete();
    end else begin
      if (cap_we) capacity = cap_wdata;
      if (rsp_valid && rsp_ready) begin
        if (pending_responses.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: response transaction with none pending: hit %0d rd %h ev %0d evk %h",
                     $time, rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
        end else begin
          want = pending_responses.pop_front();
          if (rsp.hit !== want.hit || rsp.read_value !== want.read_value ||
              rsp.evicted !== want.evicted || rsp.evicted_key !== want.evicted_key) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: mismatch exp hit %0d rd %h ev %0d evk %h,",
                        " got hit %0d rd %h ev %0d evk %h"},
                       $time, want.hit, want.read_value, want.evicted, want.evicted_key,
                       rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
          end
        end
      end
      if (req_valid && req_ready) pending_responses.push_back(lru_access(req));
    end
    outstanding = pending_responses.size();
  end

endmodule

// ----- verif/tb_lru_cache_lookup_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru cache lookup and insert testbench
// drives directed and random get/put transactions through the cache under a
// range of capacity settings, with random gaps on the request side and random
// stalls on the response side; the checker predicts and compares every response
// ----------------------------------------------------------------------------
module tb_lru_cache_lookup_insert;
  import lrucache_pkg::*;

  localparam int ENTRIES     = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 258;
  localparam int HOT_KEYS    = 12;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cap_we;
  logic [CAP_BITS-1:0]  cap_wdata;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 req_taken = 1'b0;
  int                   stall_cycles = 0;
  int                   snd_idle_pct = 38;
  int                   rcv_idle_pct = 46;
  int                   outstanding;
  int                   mismatches;
  logic [DATA_BITS-1:0] hot_keys [HOT_KEYS];

  lru_cache_lookup_insert #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (DATA_BITS),
    .VALUE_BITS(DATA_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cap_we   (cap_we),
    .cap_wdata(cap_wdata),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  lru_cache_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cap_we     (cap_we),
    .cap_wdata  (cap_wdata),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .outstanding(outstanding),
    .errors     (mismatches)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    req_taken <= req_valid && req_ready;
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(negedge clk) begin
    rsp_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(negedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [DATA_BITS-1:0] key,
                      input logic [DATA_BITS-1:0] value);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req.op    = op;
    req.key   = key;
    req.value = value;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic settle();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (ENTRIES + 4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
    settle();
    cap_we    = 1'b1;
    cap_wdata = cap;
    @(negedge clk);
    cap_we    = 1'b0;
  endtask

  initial begin
    int                   cap_plan [PHASES];
    int                   span;
    int                   n;
    logic                 op;
    logic [DATA_BITS-1:0] key;
    logic [DATA_BITS-1:0] value;
    cap_plan  = '{2, 1, 8, 15, 0, 3, 6};
    rst       = 1'b1;
    cap_we    = 1'b0;
    cap_wdata = '0;
    req_valid = 1'b0;
    req       = '0;
    n         = 0;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // zero capacity on an empty cache drops the new key at once
    set_capacity(4'd0);
    send(OP_PUT, 32'h0000_1234, 32'h0BAD_F00D);
    send(OP_GET, 32'h0000_1234, 32'h0);
    send(OP_PUT, 32'h8000_0001, 32'h7FFF_FFFE);

    set_capacity(CAP_RESET);
    send(OP_GET, 32'h0, 32'hFFFF_FFFF);
    send(OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send(OP_GET, 32'h0, 32'h0);
    send(OP_PUT, 32'hFFFF_FFFF, 32'h0);
    send(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    send(OP_PUT, 32'h1, 32'h11);
    send(OP_PUT, 32'h2, 32'h22);
    send(OP_PUT, 32'h3, 32'h33);
    send(OP_PUT, 32'h4, 32'h44);
    send(OP_GET, 32'h0, 32'h0);
    send(OP_GET, 32'h1, 32'h0);
    send(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

    // capacity lowered below occupancy: one eviction per new key
    set_capacity(4'd1);
    send(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send(OP_PUT, 32'h2, 32'h222);
    send(OP_GET, 32'h5555_5555, 32'h0);
    send(OP_GET, 32'hFFFF_FFFF, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(CAP_BITS'(cap_plan[p]));
      span = ((cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p]) + 3;
      hot_keys[$urandom_range(0, HOT_KEYS - 1)] = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (n == PHASES * PHASE_ITEMS / 3) begin
          snd_idle_pct = 46;
          rcv_idle_pct = 38;
        end else if (n == 2 * PHASES * PHASE_ITEMS / 3) begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        op  = $urandom_range(0, 1) ? OP_PUT : OP_GET;
        key = ($urandom_range(0, 99) < 85) ? hot_keys[$urandom_range(0, span - 1)] : $urandom;
        case ($urandom_range(0, 9))
          0: value = '0;
          1: value = '1;
          default: value = $urandom;
        endcase
        send(op, key, value);
        n++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
